@@ src/bmms_pkg.sv @@
// Shared types and constants for the binned min/max/mean statistics unit.
package bmms_pkg;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_BIN    = 2'd1;
    localparam logic [1:0] OP_YEAR   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic KIND_BIN  = 1'b0;
    localparam logic KIND_YEAR = 1'b1;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [3:0]        bin_index;
        logic signed [7:0] temperature;
    } cmd_t;

endpackage

@@ src/bmms_front.sv @@
// Front end: accept transactions, drop useless ones, queue the rest.
module bmms_front #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bmms_pkg::cmd_t       in_cmd,
    output logic                 q_valid,
    input  logic                 q_ready,
    output bmms_pkg::cmd_t       q_cmd
);
    import bmms_pkg::*;

    localparam int AW = $clog2(DEPTH);

    cmd_t            mem_reg [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     cnt_reg;
    logic            push, pop, keep;

    assign keep     = (in_cmd.opcode != OP_UNUSED);
    assign in_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

@@ src/bmms_back.sv @@
// Back end: per-bin store, sequencer and iterative divider.
module bmms_back #(
    parameter int BIN_COUNT  = 12,
    parameter int COUNT_BITS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  bmms_pkg::cmd_t      q_cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                report_kind,
    output logic signed [14:0]  mean_value,
    output logic signed [7:0]   minimum,
    output logic signed [7:0]   maximum,
    output logic [19:0]         sample_count,
    output logic                empty_res
);
    import bmms_pkg::*;

    localparam int BW  = $clog2(BIN_COUNT);
    localparam int SW  = COUNT_BITS + 8;
    localparam int DW  = (SW > 40) ? SW : 40;
    localparam int DVW = (COUNT_BITS > BW + 1) ? COUNT_BITS : BW + 1;
    localparam int SCW = $clog2(DW + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BDIV  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_YDIV  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic signed [7:0]      mn_reg  [BIN_COUNT];
    logic signed [7:0]      mx_reg  [BIN_COUNT];
    logic signed [SW-1:0]   sum_reg [BIN_COUNT];
    logic [COUNT_BITS-1:0]  cnt_reg [BIN_COUNT];

    logic [2:0]             st_reg;
    logic [BW-1:0]          ptr_reg;
    logic signed [7:0]      amn_reg, amx_reg;
    logic signed [DW-1:0]   tot_reg;
    logic [BW:0]            fill_reg;
    logic [DW-1:0]          rem_reg, quo_reg;
    logic [DVW-1:0]         dvs_reg;
    logic [SCW-1:0]         step_reg;
    logic                   neg_reg, yr_reg;

    logic                   o_kind_reg, o_empty_reg, o_valid_reg;
    logic signed [14:0]     o_mean_reg;
    logic signed [7:0]      o_mn_reg, o_mx_reg;
    logic [19:0]            o_cnt_reg;

    logic [3:0]             idx;
    logic                   idx_ok;
    logic [BW-1:0]          b;
    logic                   take;
    logic [DW:0]            trial;
    logic [DW-1:0]          shifted;
    logic signed [DW-1:0]   qs;
    logic signed [DW-1:0]   num;
    logic [DW-1:0]          mag;

    assign idx     = q_cmd.bin_index;
    assign idx_ok  = (idx >= 4'd1) && ({28'd0, idx} <= 32'(BIN_COUNT));
    assign b       = BW'(idx - 4'd1);
    assign q_ready = (st_reg == S_IDLE) && !o_valid_reg;
    assign take    = q_valid && q_ready;

    assign shifted = {rem_reg[DW-2:0], quo_reg[DW-1]};
    assign trial   = {1'b0, shifted} - (DW+1)'(dvs_reg);
    assign qs      = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign num     = tot_reg * DW'(100);
    assign mag     = num[DW-1] ? DW'(-num) : DW'(num);

    assign out_valid    = o_valid_reg;
    assign report_kind  = o_kind_reg;
    assign mean_value   = o_mean_reg;
    assign minimum      = o_mn_reg;
    assign maximum      = o_mx_reg;
    assign sample_count = o_cnt_reg;
    assign empty_res    = o_empty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BIN_COUNT; i++)
            begin
                mn_reg[i]  <= '0;
                mx_reg[i]  <= '0;
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
            st_reg      <= S_IDLE;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (o_valid_reg && out_ready)
            begin
                o_valid_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        case (q_cmd.opcode)
                            OP_RECORD:
                            begin
                                if (idx_ok)
                                begin
                                    if (cnt_reg[b] == '0)
                                    begin
                                        mn_reg[b] <= q_cmd.temperature;
                                        mx_reg[b] <= q_cmd.temperature;
                                    end
                                    else
                                    begin
                                        if (q_cmd.temperature < mn_reg[b])
                                            mn_reg[b] <= q_cmd.temperature;
                                        if (q_cmd.temperature > mx_reg[b])
                                            mx_reg[b] <= q_cmd.temperature;
                                    end
                                    if (cnt_reg[b] != CMAX)
                                    begin
                                        cnt_reg[b] <= cnt_reg[b] + 1'b1;
                                        sum_reg[b] <= sum_reg[b]
                                            + SW'(q_cmd.temperature);
                                    end
                                end
                            end
                            OP_BIN:
                            begin
                                o_kind_reg <= KIND_BIN;
                                if (!idx_ok || cnt_reg[b] == '0)
                                begin
                                    o_mean_reg  <= '0;
                                    o_mn_reg    <= '0;
                                    o_mx_reg    <= '0;
                                    o_cnt_reg   <= '0;
                                    o_empty_reg <= 1'b1;
                                    o_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    o_mn_reg    <= mn_reg[b];
                                    o_mx_reg    <= mx_reg[b];
                                    o_cnt_reg   <= 20'(cnt_reg[b]);
                                    o_empty_reg <= 1'b0;
                                    neg_reg     <= sum_reg[b][SW-1];
                                    quo_reg     <= DW'(sum_reg[b][SW-1]
                                        ? -sum_reg[b] : sum_reg[b]);
                                    rem_reg     <= '0;
                                    dvs_reg     <= DVW'(cnt_reg[b]);
                                    step_reg    <= '0;
                                    yr_reg      <= 1'b0;
                                    st_reg      <= S_BDIV;
                                end
                            end
                            OP_YEAR:
                            begin
                                ptr_reg  <= '0;
                                tot_reg  <= '0;
                                fill_reg <= '0;
                                amn_reg  <= '0;
                                amx_reg  <= '0;
                                st_reg   <= S_SCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_BDIV, S_YDIV:
                begin
                    if (!trial[DW])
                    begin
                        rem_reg <= trial[DW-1:0];
                        quo_reg <= {quo_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= shifted;
                        quo_reg <= {quo_reg[DW-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SCW'(DW - 1))
                    begin
                        st_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (yr_reg)
                    begin
                        o_mean_reg <= 15'(qs);
                        o_valid_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end
                    else
                    begin
                        if (o_kind_reg == KIND_YEAR)
                        begin
                            tot_reg <= tot_reg + qs;
                            st_reg  <= (ptr_reg == BW'(BIN_COUNT - 1))
                                ? S_WAIT : S_SCAN;
                            ptr_reg <= ptr_reg + 1'b1;
                        end
                        else
                        begin
                            o_mean_reg  <= 15'(qs);
                            o_valid_reg <= 1'b1;
                            st_reg      <= S_IDLE;
                        end
                    end
                end
                S_SCAN:
                begin
                    o_kind_reg <= KIND_YEAR;
                    if (cnt_reg[ptr_reg] != '0)
                    begin
                        if (fill_reg == '0 || mn_reg[ptr_reg] < amn_reg)
                            amn_reg <= mn_reg[ptr_reg];
                        if (fill_reg == '0 || mx_reg[ptr_reg] > amx_reg)
                            amx_reg <= mx_reg[ptr_reg];
                        fill_reg <= fill_reg + 1'b1;
                        neg_reg  <= sum_reg[ptr_reg][SW-1];
                        quo_reg  <= DW'(sum_reg[ptr_reg][SW-1]
                            ? -sum_reg[ptr_reg] : sum_reg[ptr_reg]);
                        rem_reg  <= '0;
                        dvs_reg  <= DVW'(cnt_reg[ptr_reg]);
                        step_reg <= '0;
                        yr_reg   <= 1'b0;
                        st_reg   <= S_BDIV;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                        if (ptr_reg == BW'(BIN_COUNT - 1))
                            st_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    o_cnt_reg <= '0;
                    o_mn_reg  <= amn_reg;
                    o_mx_reg  <= amx_reg;
                    if (fill_reg == '0)
                    begin
                        o_mean_reg  <= '0;
                        o_empty_reg <= 1'b1;
                        o_valid_reg <= 1'b1;
                        st_reg      <= S_IDLE;
                    end
                    else
                    begin
                        o_empty_reg <= 1'b0;
                        neg_reg     <= num[DW-1];
                        quo_reg     <= mag + DW'(fill_reg >> 1);
                        rem_reg     <= '0;
                        dvs_reg     <= DVW'(fill_reg);
                        step_reg    <= '0;
                        yr_reg      <= 1'b1;
                        st_reg      <= S_YDIV;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

@@ src/binned_min_max_mean_stats_unit.sv @@
// Top level of the binned min/max/mean statistics unit.
// Input channel in_valid/in_ready carries opcode, bin_index, temperature.
// Opcode 0 records a sample into bin 1..BIN_COUNT; opcode 1 reports one
// bin; opcode 2 reports the whole year; opcode 3 is dropped.
// Output channel out_valid/out_ready carries one report transaction
// for each bin or year report, in order.
// A four-entry queue sits between the front end and the back end, so the
// input keeps taking transactions while the back end works or stalls.
// Records and empty bin reports need no divide. A bin report runs the
// bit-serial divider (40 steps plus start and finish). A year report has a
// start step, one scan step per empty bin, a divide per filled bin and a
// final rounding divide. The back end takes a new transaction only when
// idle and the output register is empty.
// Reset clears every bin, the queue and the output valid flag at once.
// When the receiver stalls, the result holds in the output register and
// the back end waits; the queue then fills and in_ready drops.
module binned_min_max_mean_stats_unit #(
    parameter int BIN_COUNT  = 12,
    parameter int COUNT_BITS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [3:0]          bin_index,
    input  logic signed [7:0]   temperature,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                report_kind,
    output logic signed [14:0]  mean_value,
    output logic signed [7:0]   minimum,
    output logic signed [7:0]   maximum,
    output logic [19:0]         sample_count,
    output logic                empty_res
);
    import bmms_pkg::*;

    cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;

    assign in_cmd.opcode      = opcode;
    assign in_cmd.bin_index   = bin_index;
    assign in_cmd.temperature = temperature;

    bmms_front #(.DEPTH(4)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    bmms_back #(.BIN_COUNT(BIN_COUNT), .COUNT_BITS(COUNT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(out_valid), .out_ready(out_ready),
        .report_kind(report_kind), .mean_value(mean_value),
        .minimum(minimum), .maximum(maximum),
        .sample_count(sample_count), .empty_res(empty_res)
    );
endmodule

@@ dv/binned_min_max_mean_stats_unit_test.sv @@
// Testbench for the binned min/max/mean statistics unit with a predicting scoreboard.
module binned_min_max_mean_stats_unit_test;
    import bmms_pkg::*;

    localparam int NUM_BINS = 12;
    localparam logic [19:0] COUNT_FULL = 20'hFFFFF;

    typedef struct {
        logic               kind;
        logic signed [14:0] mean;
        logic signed [7:0]  mn;
        logic signed [7:0]  mx;
        logic [19:0]        cnt;
        logic               empty;
    } report_t;

    int error_count = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    class stats_scoreboard;
        logic signed [7:0]  bin_min [NUM_BINS];
        logic signed [7:0]  bin_max [NUM_BINS];
        longint             bin_total [NUM_BINS];
        logic [19:0]        bin_cnt [NUM_BINS];
        report_t            pending_reports [$];

        function void clear();
            for (int i = 0; i < NUM_BINS; i++)
            begin
                bin_min[i] = 0;
                bin_max[i] = 0;
                bin_total[i] = 0;
                bin_cnt[i] = 0;
            end
            pending_reports.delete();
        endfunction

        function longint truncated_mean(int b);
            if (bin_cnt[b] == 0)
                return 0;
            return bin_total[b] / longint'(bin_cnt[b]);
        endfunction

        function void note_command(logic [1:0] op, logic [3:0] idx, logic signed [7:0] t);
            report_t r;
            bit ok;
            int b;
            longint total;
            longint filled;
            longint num;
            longint mag;
            longint q;
            ok = (idx >= 1) && (idx <= NUM_BINS);
            b = ok ? idx - 1 : 0;
            r = '{kind: KIND_BIN, mean: 0, mn: 0, mx: 0, cnt: 0, empty: 1'b1};
            if (op == OP_RECORD)
            begin
                if (!ok)
                    return;
                if (bin_cnt[b] == 0)
                begin
                    bin_min[b] = t;
                    bin_max[b] = t;
                end
                else
                begin
                    if (t < bin_min[b]) bin_min[b] = t;
                    if (t > bin_max[b]) bin_max[b] = t;
                end
                if (bin_cnt[b] != COUNT_FULL)
                begin
                    bin_cnt[b]++;
                    bin_total[b] += t;
                end
            end
            else if (op == OP_BIN)
            begin
                if (ok && bin_cnt[b] != 0)
                begin
                    r.mean = truncated_mean(b);
                    r.mn = bin_min[b];
                    r.mx = bin_max[b];
                    r.cnt = bin_cnt[b];
                    r.empty = 1'b0;
                end
                pending_reports.push_back(r);
            end
            else if (op == OP_YEAR)
            begin
                r.kind = KIND_YEAR;
                total = 0;
                filled = 0;
                for (int i = 0; i < NUM_BINS; i++)
                begin
                    if (bin_cnt[i] == 0)
                        continue;
                    if (filled == 0 || bin_min[i] < r.mn) r.mn = bin_min[i];
                    if (filled == 0 || bin_max[i] > r.mx) r.mx = bin_max[i];
                    total += truncated_mean(i);
                    filled++;
                end
                if (filled != 0)
                begin
                    num = total * 100;
                    mag = num < 0 ? -num : num;
                    q = (mag + filled / 2) / filled;
                    r.mean = num < 0 ? -q : q;
                    r.empty = 1'b0;
                end
                else
                begin
                    r.mn = 0;
                    r.mx = 0;
                end
                pending_reports.push_back(r);
            end
        endfunction

        task check_report(report_t got);
            report_t want;
            if (pending_reports.size() == 0)
            begin
                report_mismatch("unexpected report", 1, 0);
                return;
            end
            want = pending_reports.pop_front();
            if (got.kind !== want.kind) report_mismatch("report_kind", got.kind, want.kind);
            if (got.mean !== want.mean) report_mismatch("mean_value", got.mean, want.mean);
            if (got.mn !== want.mn) report_mismatch("minimum", got.mn, want.mn);
            if (got.mx !== want.mx) report_mismatch("maximum", got.mx, want.mx);
            if (got.cnt !== want.cnt) report_mismatch("sample_count", got.cnt, want.cnt);
            if (got.empty !== want.empty) report_mismatch("empty_res", got.empty, want.empty);
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        opcode = '0;
    logic [3:0]        bin_index = '0;
    logic signed [7:0] temperature = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              report_kind;
    logic signed [14:0] mean_value;
    logic signed [7:0] minimum;
    logic signed [7:0] maximum;
    logic [19:0]       sample_count;
    logic              empty_res;
    bit                stimulus_done = 0;

    stats_scoreboard stats = new();

    binned_min_max_mean_stats_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .bin_index(bin_index), .temperature(temperature),
        .out_valid(out_valid), .out_ready(out_ready),
        .report_kind(report_kind), .mean_value(mean_value),
        .minimum(minimum), .maximum(maximum),
        .sample_count(sample_count), .empty_res(empty_res)
    );

    always #5 clk = ~clk;

    task automatic send_command(input logic [1:0] op, input logic [3:0] idx,
                                input logic [7:0] t);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        bin_index <= idx;
        temperature <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        stats.note_command(op, idx, t);
    endtask

    task automatic send_random_command();
        int pick;
        logic [3:0] idx;
        logic [7:0] t;
        pick = $urandom_range(0, 99);
        idx = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, NUM_BINS));
        t = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 200) - 100);
        if (pick < 70)
            send_command(OP_RECORD, idx, t);
        else if (pick < 85)
            send_command(OP_BIN, idx, t);
        else if (pick < 97)
            send_command(OP_YEAR, idx, t);
        else
            send_command(OP_UNUSED, idx, t);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            stats.check_report('{kind: report_kind, mean: mean_value, mn: minimum,
                                 mx: maximum, cnt: sample_count, empty: empty_res});
    end

    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        stats.clear();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_command(OP_YEAR, 4'd1, 8'd0);
        send_command(OP_BIN, 4'd1, 8'd0);
        send_command(OP_BIN, 4'd0, 8'd0);
        send_command(OP_BIN, 4'd15, 8'd0);
        send_command(OP_RECORD, 4'd1, 8'sd100);
        send_command(OP_RECORD, 4'd1, -8'sd100);
        send_command(OP_RECORD, 4'd1, -8'sd1);
        send_command(OP_RECORD, 4'd12, 8'h7F);
        send_command(OP_RECORD, 4'd12, 8'h80);
        send_command(OP_RECORD, 4'd0, 8'sd50);
        send_command(OP_RECORD, 4'd13, 8'sd50);
        send_command(OP_RECORD, 4'd2, -8'sd7);
        send_command(OP_RECORD, 4'd2, -8'sd8);
        send_command(OP_RECORD, 4'd3, 8'sd1);
        send_command(OP_UNUSED, 4'd1, 8'sd5);
        send_command(OP_BIN, 4'd1, 8'd0);
        send_command(OP_BIN, 4'd2, 8'd0);
        send_command(OP_BIN, 4'd12, 8'hFF);
        send_command(OP_YEAR, 4'd0, 8'd0);
        for (int n = 0; n < 700; n++)
            send_random_command();
        send_command(OP_YEAR, 4'd1, 8'd0);
        in_valid <= 1'b0;
        stimulus_done = 1;
    end

    initial
    begin
        wait (stimulus_done);
        while (stats.pending_reports.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
